/* design/alr_pkg.sv */
package alr_pkg;

	localparam int unsigned ALR_DEPTH = 32;
	localparam int unsigned CNT_W     = 6;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned TDATA_W   = 48;
	localparam logic [CNT_W-1:0] INIT_CAP = CNT_W'(16);

	typedef enum logic [3:0] {
		OP_READ     = 4'd0,
		OP_WRITE    = 4'd1,
		OP_APPEND   = 4'd2,
		OP_DROP     = 4'd3,
		OP_RESIZE   = 4'd4,
		OP_SUM      = 4'd5,
		OP_INC      = 4'd6,
		OP_CONTAINS = 4'd7,
		OP_COUNT    = 4'd8,
		OP_MIN      = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// first member sits in the highest bits
	typedef struct packed {
		logic [CNT_W-1:0]         new_capacity;
		logic signed [WORD_W-1:0] value;
		logic [4:0]               index;
		logic [3:0]               op;
	} item_t;

	typedef struct packed {
		status_t                  status;
		logic [CNT_W-1:0]         length;
		logic                     found;
		logic signed [WORD_W-1:0] result_value;
	} result_t;

	localparam int unsigned ITEM_W = $bits(item_t);
	localparam int unsigned RES_W  = $bits(result_t);

	typedef struct packed {
		logic load;
		logic exec;
		logic walk;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_go;
		logic walk_last;
	} dp_stat_t;

endpackage

/* design/alr_ctrl.sv */
module alr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  alr_pkg::dp_stat_t     stat,
	output alr_pkg::ctrl_cmd_t    cmd
);
	import alr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_WALK  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.walk_go ? S_WALK : S_DONE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/alr_dpath.sv */
module alr_dpath #(
	parameter int unsigned DEPTH = alr_pkg::ALR_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alr_pkg::ctrl_cmd_t    cmd,
	output alr_pkg::dp_stat_t     stat,
	input  alr_pkg::item_t        item,
	output alr_pkg::result_t      res
);
	import alr_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_SAT =
		(DEPTH >= (2 ** CNT_W)) ? {CNT_W{1'b1}} : CNT_W'(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];

	item_t             item_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	status_t           status_q;
	logic [WORD_W-1:0] acc_q;
	logic              found_q;
	logic [CNT_W-1:0]  walk_idx_q;
	result_t           res_q;

	logic              rd_vld_s1;
	logic              rd_first_s1;
	logic [AW-1:0]     rd_addr_s1;
	logic [WORD_W-1:0] rdata_s1;

	logic              idx_ok;
	logic              full;
	logic              empty;
	logic              is_walk;
	logic [CNT_W-1:0]  ncap_sat;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              inc_wb;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] result_val;

	assign idx_ok   = {1'b0, item_q.index} < count_q;
	assign full     = count_q >= cap_q;
	assign empty    = (count_q == '0);
	assign ncap_sat = (item_q.new_capacity > DEPTH_SAT) ? DEPTH_SAT : item_q.new_capacity;
	assign is_walk  = (item_q.op == OP_SUM) || (item_q.op == OP_INC) ||
		(item_q.op == OP_CONTAINS) || (item_q.op == OP_COUNT) || (item_q.op == OP_MIN);

	assign stat.walk_go   = is_walk && !empty;
	assign stat.walk_last = (walk_idx_q == count_q - CNT_W'(1));

	// one read port: single reads and the entry walk
	assign rd_en   = (cmd.exec && item_q.op == OP_READ) || cmd.walk;
	assign rd_addr = cmd.walk ? AW'(walk_idx_q) : AW'(item_q.index);

	// increment-all writes each entry back in the cycle after its read
	assign inc_wb  = rd_vld_s1 && (item_q.op == OP_INC);
	assign wr_en   = (cmd.exec && item_q.op == OP_WRITE && idx_ok) ||
		(cmd.exec && item_q.op == OP_APPEND && !full) || inc_wb;
	assign wr_addr = inc_wb ? rd_addr_s1 :
		((item_q.op == OP_APPEND) ? AW'(count_q) : AW'(item_q.index));
	assign wr_data = inc_wb ? (rdata_s1 + WORD_W'(1)) : item_q.value;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_comb begin
		unique case (item_q.op)
			OP_READ:   result_val = (status_q == ST_OK) ? rdata_s1 : '0;
			OP_WRITE,
			OP_APPEND,
			OP_SUM,
			OP_COUNT,
			OP_MIN:    result_val = acc_q;
			default:   result_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cap_q     <= INIT_CAP;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.walk;
			if (cmd.exec) begin
				unique case (item_q.op)
					OP_APPEND: begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					OP_DROP: begin
						if (!empty) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
					OP_RESIZE: begin
						cap_q <= ncap_sat;
						if (count_q > ncap_sat) begin
							count_q <= ncap_sat;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q     <= item;
			status_q   <= ST_OK;
			acc_q      <= '0;
			found_q    <= 1'b0;
			walk_idx_q <= '0;
		end
		if (cmd.exec) begin
			unique case (item_q.op)
				OP_READ: begin
					if (!idx_ok) begin
						status_q <= ST_RANGE;
					end
				end
				OP_WRITE: begin
					if (idx_ok) begin
						acc_q <= item_q.value;
					end else begin
						status_q <= ST_RANGE;
					end
				end
				OP_APPEND: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						acc_q <= item_q.value;
					end
				end
				OP_DROP,
				OP_MIN: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.walk) begin
			walk_idx_q  <= walk_idx_q + CNT_W'(1);
			rd_addr_s1  <= rd_addr;
			rd_first_s1 <= (walk_idx_q == '0);
		end
		if (rd_vld_s1) begin
			unique case (item_q.op)
				OP_SUM: begin
					acc_q <= acc_q + rdata_s1;
				end
				OP_CONTAINS: begin
					if (rdata_s1 == item_q.value) begin
						found_q <= 1'b1;
					end
				end
				OP_COUNT: begin
					if (rdata_s1 == item_q.value) begin
						acc_q <= acc_q + WORD_W'(1);
					end
				end
				OP_MIN: begin
					if (rd_first_s1 || ($signed(rdata_s1) < $signed(acc_q))) begin
						acc_q <= rdata_s1;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.finish) begin
			res_q.result_value <= result_val;
			res_q.found        <= found_q;
			res_q.length       <= count_q;
			res_q.status       <= status_q;
		end
	end

	assign res = res_q;

endmodule

/* design/array_list_with_reductions.sv */
// Bounded list of signed 32-bit words with a length and a capacity (16 after reset,
// resize saturates at DEPTH). Each input beat carries one operation and gives exactly
// one result beat with the length after the operation and a status. Read, write,
// append, drop last, resize and unused codes go from accept through execute to
// finish; sum, increment all, contains, count and minimum also walk the stored
// entries through the single read port of the entry memory, one entry a cycle, and
// drain the last read before finish, unless the list is empty. A finished item
// waits in its finish state until the output register is free. A new item is taken
// while the previous result still waits in the output register. The entry memory is
// not cleared at reset; only entries below the length ever reach a result.
module array_list_with_reductions #(
	parameter int unsigned DEPTH = alr_pkg::ALR_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// op[3:0], index[8:4], value[40:9], new_capacity[46:41], zero pad
	input  logic [alr_pkg::TDATA_W-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// result_value[31:0], found[32], length[38:33], status[40:39], zero pad
	output logic [alr_pkg::TDATA_W-1:0]  m_tdata
);
	import alr_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	item_t     item;
	result_t   res_data;

	assign item    = s_tdata[ITEM_W-1:0];
	assign m_tdata = {{(TDATA_W-RES_W){1'b0}}, res_data};

	alr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	alr_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.item   (item),
		.res    (res_data)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("accepted item not executed next cycle");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.finish))
		else $error("result beat without a finished item");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(res_data.length) <= int'(DEPTH)))
		else $error("reported length above depth");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import alr_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned RAND_ITEMS   = 1330;
	localparam int unsigned DRAIN_CYCLES = ALR_DEPTH + 8;
	localparam logic [3:0]  OP_SPARE_TOP = 4'hf;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} dir_row_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;

	logic [WORD_W-1:0] shadow_words [ALR_DEPTH];
	int unsigned       shadow_len;
	int unsigned       shadow_cap;
	result_t           pending_results [$];
	dir_row_t          dir_rows [$];
	int unsigned       mismatches  = 0;
	int unsigned       idle_cycles = 0;
	bit                calm        = 1'b0;

	array_list_with_reductions u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t list_predict(item_t it);
		result_t           r;
		int unsigned       nc;
		logic [WORD_W-1:0] acc;
		r = '0;
		r.status = ST_OK;
		acc = '0;
		case (it.op)
			OP_READ: begin
				if (it.index < shadow_len) r.result_value = shadow_words[it.index];
				else r.status = ST_RANGE;
			end
			OP_WRITE: begin
				if (it.index < shadow_len) begin
					shadow_words[it.index] = it.value;
					r.result_value = it.value;
				end else begin
					r.status = ST_RANGE;
				end
			end
			OP_APPEND: begin
				if (shadow_len >= shadow_cap || shadow_len >= ALR_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_words[shadow_len] = it.value;
					shadow_len++;
					r.result_value = it.value;
				end
			end
			OP_DROP: begin
				if (shadow_len == 0) r.status = ST_EMPTY;
				else shadow_len--;
			end
			OP_RESIZE: begin
				nc = (it.new_capacity > ALR_DEPTH) ? ALR_DEPTH : it.new_capacity;
				if (shadow_len > nc) shadow_len = nc;
				shadow_cap = nc;
			end
			OP_SUM: begin
				for (int i = 0; i < shadow_len; i++) acc += shadow_words[i];
				r.result_value = acc;
			end
			OP_INC: begin
				for (int i = 0; i < shadow_len; i++) shadow_words[i] += 1;
			end
			OP_CONTAINS: begin
				for (int i = 0; i < shadow_len; i++)
					if (shadow_words[i] == it.value) r.found = 1'b1;
			end
			OP_COUNT: begin
				for (int i = 0; i < shadow_len; i++)
					if (shadow_words[i] == it.value) acc++;
				r.result_value = acc;
			end
			OP_MIN: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					acc = shadow_words[0];
					for (int i = 1; i < shadow_len; i++)
						if ($signed(shadow_words[i]) < $signed(acc)) acc = shadow_words[i];
					r.result_value = acc;
				end
			end
			default: begin
			end
		endcase
		r.length = CNT_W'(shadow_len);
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			4: return WORD_W'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t gen_item();
		item_t       it;
		int unsigned sel;
		it.op = OP_READ;
		it.index = 5'($urandom);
		it.value = pick_word();
		it.new_capacity = 6'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			it.op = OP_APPEND;
		end else if (sel < 50) begin
			it.op = (sel < 40) ? OP_READ : OP_WRITE;
			if (shadow_len > 0 && $urandom_range(0, 7) != 0)
				it.index = 5'($urandom_range(0, shadow_len - 1));
		end else if (sel < 58) begin
			it.op = OP_DROP;
		end else if (sel < 62) begin
			it.op = OP_RESIZE;
			if ($urandom_range(0, 2) == 0) it.new_capacity = 6'($urandom_range(0, shadow_len));
		end else if (sel < 92) begin
			it.op = 4'($urandom_range(int'(OP_SUM), int'(OP_MIN)));
			if ((it.op == OP_CONTAINS || it.op == OP_COUNT) && shadow_len > 0
					&& $urandom_range(0, 1) == 1)
				it.value = shadow_words[$urandom_range(0, shadow_len - 1)];
		end else if (sel < 96) begin
			it.op = 4'($urandom_range(int'(OP_MIN) + 1, int'(OP_SPARE_TOP)));
		end else begin
			it.op = 4'($urandom);
		end
		return it;
	endfunction

	function automatic void add_row(input logic [3:0] op, input logic [4:0] idx,
			input logic [WORD_W-1:0] val, input logic [CNT_W-1:0] ncap, input bit typed,
			input logic [WORD_W-1:0] rv, input logic fnd, input logic [CNT_W-1:0] len,
			input status_t st);
		dir_row_t row;
		row.it.op = op;
		row.it.index = idx;
		row.it.value = val;
		row.it.new_capacity = ncap;
		row.typed = typed;
		row.res.result_value = rv;
		row.res.found = fnd;
		row.res.length = len;
		row.res.status = st;
		dir_rows.push_back(row);
	endfunction

	task automatic send_beat(input item_t it, input bit typed, input result_t fixed_res);
		int unsigned gap;
		result_t     r;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(TDATA_W - ITEM_W){1'b0}}, it};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = list_predict(it);
		pending_results.push_back(typed ? fixed_res : r);
	endtask

	initial begin : result_sink
		int unsigned stall;
		result_t     got;
		result_t     want;
		wait (arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got = m_tdata[RES_W-1:0];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: value %0d found %0b length %0d status %0d",
						got.result_value, got.found, got.length, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got.result_value !== want.result_value || got.found !== want.found
						|| got.length !== want.length || got.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected value %0d found %0b length %0d status %0d,",
							" got value %0d found %0b length %0d status %0d"},
							want.result_value, want.found, want.length, want.status,
							got.result_value, got.found, got.length, got.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("array_list_with_reductions regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		shadow_len = 0;
		shadow_cap = INIT_CAP;

		// empty list after reset
		add_row(OP_READ, 0, 0, 0, 1, 0, 0, 0, ST_RANGE);
		add_row(OP_DROP, 0, 0, 0, 1, 0, 0, 0, ST_EMPTY);
		add_row(OP_MIN, 0, 0, 0, 1, 0, 0, 0, ST_EMPTY);
		add_row(OP_SUM, 0, 0, 0, 1, 0, 0, 0, ST_OK);
		add_row(OP_CONTAINS, 0, 0, 0, 1, 0, 0, 0, ST_OK);
		add_row(OP_COUNT, 0, 0, 0, 1, 0, 0, 0, ST_OK);
		add_row(OP_WRITE, 5'd31, 32'hffff_ffff, 0, 1, 0, 0, 0, ST_RANGE);
		// word extremes
		add_row(OP_APPEND, 0, 32'h7fff_ffff, 0, 1, 32'h7fff_ffff, 0, 1, ST_OK);
		add_row(OP_APPEND, 0, 32'h8000_0000, 0, 1, 32'h8000_0000, 0, 2, ST_OK);
		add_row(OP_APPEND, 0, 32'hffff_ffff, 0, 1, 32'hffff_ffff, 0, 3, ST_OK);
		add_row(OP_READ, 1, 0, 0, 1, 32'h8000_0000, 0, 3, ST_OK);
		add_row(OP_READ, 3, 0, 0, 1, 0, 0, 3, ST_RANGE);
		add_row(OP_SUM, 0, 0, 0, 0, 0, 0, 0, ST_OK);
		add_row(OP_MIN, 0, 0, 0, 1, 32'h8000_0000, 0, 3, ST_OK);
		add_row(OP_CONTAINS, 0, 32'h8000_0000, 0, 1, 0, 1, 3, ST_OK);
		add_row(OP_INC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
		add_row(OP_COUNT, 0, 32'h8000_0000, 0, 0, 0, 0, 0, ST_OK);
		add_row(OP_WRITE, 2, 32'h1234_5678, 0, 1, 32'h1234_5678, 0, 3, ST_OK);
		add_row(OP_SPARE_TOP, 5'd31, 32'hffff_ffff, 6'd63, 1, 0, 0, 3, ST_OK);
		// capacity saturation, truncation and full list
		add_row(OP_RESIZE, 0, 0, 6'd63, 1, 0, 0, 3, ST_OK);
		add_row(OP_RESIZE, 0, 0, 6'd1, 1, 0, 0, 1, ST_OK);
		add_row(OP_APPEND, 0, 32'd5, 0, 1, 0, 0, 1, ST_FULL);
		add_row(OP_RESIZE, 0, 0, 6'd0, 1, 0, 0, 0, ST_OK);
		add_row(OP_APPEND, 0, 32'd7, 0, 1, 0, 0, 0, ST_FULL);
		add_row(OP_RESIZE, 0, 0, 6'd32, 1, 0, 0, 0, ST_OK);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) send_beat(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
			if (n == RAND_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			send_beat(gen_item(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("array_list_with_reductions regression: pass");
		end else begin
			$display("array_list_with_reductions regression: fail");
		end
		$finish;
	end

endmodule
